@@ rtl/crw_pkg.sv @@
// ---------------------------------------------------------------------------
// crw_pkg: shared types and constants
// Word layouts, opcodes, status codes and controller/datapath links for the
// completion reorder window.
// ---------------------------------------------------------------------------
package crw_pkg;

  localparam int MAX_SLOTS_DEF = 32;
  localparam int CNT_W         = 6;
  localparam int WORD_W        = 32;
  localparam int LEASE_W       = 64;
  localparam int CFG_IDX_W     = 2;

  localparam logic [1:0] OP_ADMIT    = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IDENTITY = 3'd1;
  localparam logic [2:0] ST_CREDIT   = 3'd2;
  localparam logic [2:0] ST_NOSTART  = 3'd3;
  localparam logic [2:0] ST_STALE    = 3'd4;

  localparam logic [1:0] PH_EMPTY   = 2'd0;
  localparam logic [1:0] PH_ACTIVE  = 2'd1;
  localparam logic [1:0] PH_PENDING = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [WORD_W-1:0]  epoch_tag;
    logic [WORD_W-1:0]  block_index;
    logic [LEASE_W-1:0] lease_tag;
    logic               time_moves;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              can_admit_flag;
    logic              ready_flag;
    logic [WORD_W-1:0] frontier_out;
    logic              finished_flag;
    logic [WORD_W-1:0] admitted_total;
    logic [WORD_W-1:0] completed_total;
    logic [CNT_W-1:0]  peak_used;
    logic [CNT_W-1:0]  active_now;
    logic [CNT_W-1:0]  pending_now;
    logic [CNT_W-1:0]  done_now;
    logic [WORD_W-1:0] change_total;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic retire;
    logic load_out;
  } crw_cmd_t;

  typedef struct packed {
    logic rem_done;
    logic is_tick;
    logic retire_more;
  } crw_sts_t;

endpackage

@@ rtl/crw_if.sv @@
// ---------------------------------------------------------------------------
// crw_in_if / crw_out_if: valid/ready channels
// One word moves per cycle in which valid and ready are both high.
// ---------------------------------------------------------------------------
interface crw_in_if import crw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crw_out_if import crw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/crw_rem.sv @@
// ---------------------------------------------------------------------------
// crw_rem: bit-serial remainder unit
// Computes a 32-bit value mod a 6-bit divisor, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module crw_rem
  import crw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic [CNT_W-1:0]  rem,
  output logic              done
);

  logic [WORD_W-1:0] num_r;
  logic [CNT_W-1:0]  rem_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    reduced;

  // shift in the next dividend bit and reduce once
  always_comb begin
    trial   = {rem_r, num_r[WORD_W-1]};
    reduced = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[WORD_W-2:0], 1'b0};
      rem_r <= reduced[CNT_W-1:0];
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

@@ rtl/crw_datapath.sv @@
// ---------------------------------------------------------------------------
// crw_datapath: slot store, counters and result register
// Executes one operation under controller commands and builds the result word.
// ---------------------------------------------------------------------------
module crw_datapath
  import crw_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crw_cmd_t             cmd,
  output crw_sts_t             sts,
  input  in_word_t             in_data,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CAP = CNT_W'(MAX_SLOTS);

  logic [WORD_W-1:0]  epoch_r, blocks_r;
  logic [CNT_W-1:0]   slots_r;
  in_word_t           item_r;
  logic [1:0]         phase_r [MAX_SLOTS];
  logic [WORD_W-1:0]  blk_r   [MAX_SLOTS];
  logic [LEASE_W-1:0] lease_r [MAX_SLOTS];
  logic [WORD_W-1:0]  rp_r, admit_r, compl_r, rev_r;
  logic               running_r;
  logic [CNT_W-1:0]   peak_r, act_r, pend_r, done_r;
  logic [SLOT_W-1:0]  ret_slot_r;
  logic [2:0]         st_r;
  logic               can_r, rdy_r;
  out_word_t          out_r;

  logic [CNT_W-1:0]   cap;
  logic [CNT_W-1:0]   rem;
  logic               rem_done;
  logic [SLOT_W-1:0]  slot;
  logic [WORD_W-1:0]  blk, ahead;
  logic               id_ok, in_win, adm, rdy, match;
  logic [1:0]         ph;
  logic [2:0]         st_nxt;
  logic               ret_ok;
  logic [WORD_W:0]    rev_sum;
  logic [CNT_W-1:0]   used_nxt;
  logic [CNT_W-1:0]   ret_inc;

  // clamp the slot register into 1..MAX_SLOTS
  always_comb begin
    if (slots_r == '0)          cap = CNT_W'(1);
    else if (slots_r > MAX_CAP) cap = MAX_CAP;
    else                        cap = slots_r;
  end

  crw_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.capture),
    .dividend ((in_data.opcode == OP_TICK) ? rp_r : in_data.block_index),
    .divisor  (cap),
    .rem      (rem),
    .done     (rem_done)
  );

  // decide the operation outcome
  always_comb begin
    slot   = rem[SLOT_W-1:0];
    blk    = item_r.block_index;
    ahead  = blk - rp_r;
    ph     = phase_r[slot];
    id_ok  = (item_r.epoch_tag == epoch_r) && (blk < blocks_r);
    in_win = (blk >= rp_r) && (ahead < {{(WORD_W-CNT_W){1'b0}}, cap});
    adm    = running_r && in_win && (ph == PH_EMPTY);
    rdy    = (blk < rp_r) || (in_win && (blk_r[slot] == blk) && (ph == PH_DONE));
    match  = (ph == PH_ACTIVE) && (blk_r[slot] == blk) &&
             (lease_r[slot] == item_r.lease_tag);
    st_nxt = ST_OK;
    case (item_r.opcode)
      OP_ADMIT: begin
        if (item_r.lease_tag == '0) st_nxt = ST_CREDIT;
        else if (!id_ok)            st_nxt = ST_IDENTITY;
        else if (!adm)              st_nxt = ST_CREDIT;
      end
      OP_COMPLETE: begin
        if (!id_ok)           st_nxt = ST_IDENTITY;
        else if (!running_r)  st_nxt = ST_NOSTART;
        else if (!match)      st_nxt = ST_STALE;
      end
      OP_QUERY: begin
        if (!id_ok) st_nxt = ST_IDENTITY;
      end
      default: st_nxt = ST_OK;
    endcase
    ret_ok   = (rp_r < blocks_r) && (phase_r[ret_slot_r] == PH_DONE) &&
               (blk_r[ret_slot_r] == rp_r);
    rev_sum  = {1'b0, rev_r} + {{(WORD_W+1-CNT_W){1'b0}}, pend_r};
    used_nxt = act_r + pend_r + done_r + CNT_W'(1);
    ret_inc  = CNT_W'(ret_slot_r) + CNT_W'(1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r  <= WORD_W'(1);
      blocks_r <= WORD_W'(1);
      slots_r  <= CNT_W'(32);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_EPOCH:  epoch_r  <= cfg_wdata;
        CFG_BLOCKS: blocks_r <= cfg_wdata;
        CFG_SLOTS:  slots_r  <= cfg_wdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // window control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) phase_r[i] <= PH_EMPTY;
      rp_r <= '0; running_r <= 1'b0;
      admit_r <= '0; compl_r <= '0; rev_r <= '0;
      peak_r <= '0; act_r <= '0; pend_r <= '0; done_r <= '0;
      ret_slot_r <= '0;
    end else if (cmd.exec) begin
      if (item_r.opcode == OP_TICK) begin
        running_r  <= 1'b1;
        ret_slot_r <= slot;
        if (item_r.time_moves) begin
          for (int i = 0; i < MAX_SLOTS; i++)
            if (phase_r[i] == PH_PENDING) phase_r[i] <= PH_DONE;
          done_r <= done_r + pend_r;
          pend_r <= '0;
          rev_r  <= rev_sum[WORD_W] ? '1 : rev_sum[WORD_W-1:0];
        end
      end else if (item_r.opcode == OP_ADMIT && st_nxt == ST_OK) begin
        phase_r[slot] <= PH_ACTIVE;
        act_r <= act_r + CNT_W'(1);
        if (admit_r != '1) admit_r <= admit_r + WORD_W'(1);
        if (rev_r != '1)   rev_r   <= rev_r + WORD_W'(1);
        if (used_nxt > peak_r) peak_r <= used_nxt;
      end else if (item_r.opcode == OP_COMPLETE && st_nxt == ST_OK) begin
        phase_r[slot] <= PH_PENDING;
        act_r  <= act_r - CNT_W'(1);
        pend_r <= pend_r + CNT_W'(1);
        if (compl_r != '1) compl_r <= compl_r + WORD_W'(1);
        if (rev_r != '1)   rev_r   <= rev_r + WORD_W'(1);
      end
    end else if (cmd.retire && ret_ok) begin
      // retire the frontier entry and advance
      phase_r[ret_slot_r] <= PH_EMPTY;
      done_r <= done_r - CNT_W'(1);
      rp_r   <= rp_r + WORD_W'(1);
      if (rev_r != '1) rev_r <= rev_r + WORD_W'(1);
      ret_slot_r <= (ret_inc == cap) ? '0 : ret_inc[SLOT_W-1:0];
    end
  end

  // slot payload, written on admit
  always_ff @(posedge clk) begin
    if (cmd.exec && item_r.opcode == OP_ADMIT && st_nxt == ST_OK) begin
      blk_r[slot]   <= blk;
      lease_r[slot] <= item_r.lease_tag;
    end
  end

  // hold the item, the outcome and the result word
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.exec) begin
      st_r  <= st_nxt;
      can_r <= (item_r.opcode == OP_QUERY) && id_ok && adm;
      rdy_r <= (item_r.opcode == OP_QUERY) && id_ok && rdy;
    end
    if (cmd.load_out) begin
      out_r.status          <= st_r;
      out_r.can_admit_flag  <= can_r;
      out_r.ready_flag      <= rdy_r;
      out_r.frontier_out    <= rp_r;
      out_r.finished_flag   <= (rp_r >= blocks_r);
      out_r.admitted_total  <= admit_r;
      out_r.completed_total <= compl_r;
      out_r.peak_used       <= peak_r;
      out_r.active_now      <= act_r;
      out_r.pending_now     <= pend_r;
      out_r.done_now        <= done_r;
      out_r.change_total    <= rev_r;
    end
  end

  assign out_data        = out_r;
  assign sts.rem_done    = rem_done;
  assign sts.is_tick     = (item_r.opcode == OP_TICK);
  assign sts.retire_more = ret_ok;

endmodule

@@ rtl/crw_ctrl.sv @@
// ---------------------------------------------------------------------------
// crw_ctrl: operation sequencer
// Steps each word through slot lookup, execute, retire (ticks only) and result hand-off.
// ---------------------------------------------------------------------------
module crw_ctrl
  import crw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output crw_cmd_t cmd,
  input  crw_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REM  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_RET  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  // sequence one operation
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    out_free     = !ovalid_r || out_ready;
    ovalid_nxt   = ovalid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_REM;
        end
      end
      S_REM:  if (sts.rem_done) state_nxt = S_EXEC;
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_tick ? S_RET : S_OUT;
      end
      S_RET: begin
        cmd.retire = 1'b1;
        if (!sts.retire_more) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

endmodule

@@ rtl/completion_reorder_window.sv @@
// Sequence: a word is accepted in the idle state and its slot index is computed by the
// bit-serial slot-index remainder unit (one dividend bit per cycle); the word then executes,
// a tick retires done entries at the frontier in order (up to slot_count), and the result
// is loaded once the output register is free. A new word is taken only after that load.
// Reset (synchronous, rst_n low): window empty, not running, counters zero,
// registers to epoch 1, one block, 32 slots.
// ---------------------------------------------------------------------------
// completion_reorder_window: in-order retirement window over numbered blocks
// Admit, complete, tick and query operations with one result word each.
// ---------------------------------------------------------------------------
module completion_reorder_window
  import crw_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  crw_in_if.sink               in_ch,
  crw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  crw_cmd_t cmd;
  crw_sts_t sts;

  crw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  crw_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_data  (out_ch.data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word taken while busy");

  a_flags_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.status != ST_OK) |->
      (!out_ch.data.can_admit_flag && !out_ch.data.ready_flag))
    else $error("flag set on rejected word");

  a_slot_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_ch.data.active_now} + {1'b0, out_ch.data.pending_now}
      + {1'b0, out_ch.data.done_now} <= (CNT_W+1)'(MAX_SLOTS)))
    else $error("slot phase counts exceed slot store");
`endif

endmodule

@@ dv/crw_tb_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crw_tb_if: testbench view of the window channels
// The bench instantiates the crw_in_if and crw_out_if channels from the rtl
// interface file, so nothing else is declared here.
// ---------------------------------------------------------------------------

@@ dv/completion_reorder_window_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// completion_reorder_window_tb: self-checking bench for the reorder window
// Drives admit/complete/tick/query words under random stalls and several
// register settings, predicts every result word and compares field by field.
// ---------------------------------------------------------------------------
module completion_reorder_window_tb;
  import crw_pkg::*;

  localparam int NSLOT = MAX_SLOTS_DEF;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0] cfg_wdata;

  crw_in_if in_ch ();
  crw_out_if out_ch ();

  completion_reorder_window dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // window shadow state
  logic [31:0] w_epoch, w_blocks;
  logic [5:0]  w_slots;
  logic [31:0] s_block [NSLOT];
  logic [63:0] s_lease [NSLOT];
  logic [1:0]  s_phase [NSLOT];
  logic [31:0] frontier, n_admit, n_complete, n_change;
  logic        started;
  logic [5:0]  peak;

  in_word_t  send_q [$];
  out_word_t expect_q [$];
  int errors = 0;
  int n_words = 0;
  int n_ticks_retired = 0;
  bit hold_off = 0;
  int sent = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function automatic int span();
    if (w_slots == 0) return 1;
    if (w_slots > NSLOT) return NSLOT;
    return w_slots;
  endfunction

  function automatic bit id_ok(logic [31:0] tag, logic [31:0] blk);
    return tag == w_epoch && blk < w_blocks;
  endfunction

  function automatic bit may_admit(logic [31:0] blk);
    int c;
    c = span();
    if (!started || blk < frontier) return 0;
    if (blk - frontier >= c) return 0;
    return s_phase[blk % c] == PH_EMPTY;
  endfunction

  function automatic bit is_ready(logic [31:0] blk);
    int c;
    int s;
    c = span();
    if (blk < frontier) return 1;
    if (blk - frontier >= c) return 0;
    s = blk % c;
    return s_block[s] == blk && s_phase[s] == PH_DONE;
  endfunction

  function automatic void window_reset();
    w_epoch = 1; w_blocks = 1; w_slots = 32;
    for (int i = 0; i < NSLOT; i++) begin
      s_block[i] = 0; s_lease[i] = 0; s_phase[i] = PH_EMPTY;
    end
    frontier = 0; started = 0; n_admit = 0; n_complete = 0; n_change = 0; peak = 0;
  endfunction

  // advance the shadow window by one word and return the expected result
  function automatic out_word_t window_step(in_word_t w);
    out_word_t r;
    int c;
    int s;
    int used;
    int na;
    int np;
    int nd;
    c = span();
    r = '0;
    r.status = ST_OK;
    case (w.opcode)
      OP_ADMIT: begin
        if (w.lease_tag == 0) r.status = ST_CREDIT;
        else if (!id_ok(w.epoch_tag, w.block_index)) r.status = ST_IDENTITY;
        else if (!may_admit(w.block_index)) r.status = ST_CREDIT;
        else begin
          s = w.block_index % c;
          s_block[s] = w.block_index; s_lease[s] = w.lease_tag; s_phase[s] = PH_ACTIVE;
          n_admit = sat_up(n_admit); n_change = sat_up(n_change);
          used = 0;
          for (int i = 0; i < NSLOT; i++) used += (s_phase[i] != PH_EMPTY);
          if (used > peak) peak = used;
        end
      end
      OP_COMPLETE: begin
        if (!id_ok(w.epoch_tag, w.block_index)) r.status = ST_IDENTITY;
        else if (!started) r.status = ST_NOSTART;
        else begin
          s = w.block_index % c;
          if (s_phase[s] != PH_ACTIVE || s_block[s] != w.block_index ||
              s_lease[s] != w.lease_tag) r.status = ST_STALE;
          else begin
            s_phase[s] = PH_PENDING;
            n_complete = sat_up(n_complete); n_change = sat_up(n_change);
          end
        end
      end
      OP_TICK: begin
        started = 1;
        if (w.time_moves)
          for (int i = 0; i < NSLOT; i++)
            if (s_phase[i] == PH_PENDING) begin
              s_phase[i] = PH_DONE; n_change = sat_up(n_change);
            end
        for (int i = 0; i <= NSLOT && frontier < w_blocks; i++) begin
          s = frontier % c;
          if (s_phase[s] != PH_DONE || s_block[s] != frontier) break;
          s_phase[s] = PH_EMPTY; s_block[s] = 0; s_lease[s] = 0;
          frontier++; n_change = sat_up(n_change); n_ticks_retired++;
        end
      end
      default: begin
        if (!id_ok(w.epoch_tag, w.block_index)) r.status = ST_IDENTITY;
        else begin
          r.can_admit_flag = may_admit(w.block_index);
          r.ready_flag = is_ready(w.block_index);
        end
      end
    endcase
    na = 0; np = 0; nd = 0;
    for (int i = 0; i < NSLOT; i++) begin
      na += (s_phase[i] == PH_ACTIVE);
      np += (s_phase[i] == PH_PENDING);
      nd += (s_phase[i] == PH_DONE);
    end
    r.frontier_out = frontier;
    r.finished_flag = frontier >= w_blocks;
    r.admitted_total = n_admit;
    r.completed_total = n_complete;
    r.peak_used = peak;
    r.active_now = na;
    r.pending_now = np;
    r.done_now = nd;
    r.change_total = n_change;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: offer queued words, hold data while stalled
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expect_q.push_back(window_step(in_ch.data));
        sent++;
      end
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (send_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= send_q.pop_front();
        send_gap <= gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // monitor: compare each result word with the oldest prediction
  int recv_gap = 0;
  always @(posedge clk) begin
    out_word_t g;
    out_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        g = out_ch.data;
        n_words++;
        if (expect_q.size() == 0) report_mismatch("unexpected word", g.status, 0);
        else begin
          e = expect_q.pop_front();
          if (g.status !== e.status) report_mismatch("status", g.status, e.status);
          if (g.can_admit_flag !== e.can_admit_flag)
            report_mismatch("can_admit_flag", g.can_admit_flag, e.can_admit_flag);
          if (g.ready_flag !== e.ready_flag)
            report_mismatch("ready_flag", g.ready_flag, e.ready_flag);
          if (g.frontier_out !== e.frontier_out)
            report_mismatch("frontier_out", g.frontier_out, e.frontier_out);
          if (g.finished_flag !== e.finished_flag)
            report_mismatch("finished_flag", g.finished_flag, e.finished_flag);
          if (g.admitted_total !== e.admitted_total)
            report_mismatch("admitted_total", g.admitted_total, e.admitted_total);
          if (g.completed_total !== e.completed_total)
            report_mismatch("completed_total", g.completed_total, e.completed_total);
          if (g.peak_used !== e.peak_used) report_mismatch("peak_used", g.peak_used, e.peak_used);
          if (g.active_now !== e.active_now)
            report_mismatch("active_now", g.active_now, e.active_now);
          if (g.pending_now !== e.pending_now)
            report_mismatch("pending_now", g.pending_now, e.pending_now);
          if (g.done_now !== e.done_now) report_mismatch("done_now", g.done_now, e.done_now);
          if (g.change_total !== e.change_total)
            report_mismatch("change_total", g.change_total, e.change_total);
        end
      end
      if (hold_off) out_ch.ready <= 1'b0;
      else if (recv_gap > 0) begin
        out_ch.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap <= gap_len();
      end
    end
  end

  // push one word
  task automatic queue_word(logic [1:0] op, logic [31:0] tag, logic [31:0] blk,
                            logic [63:0] lease, logic moves);
    in_word_t w;
    w.opcode = op; w.epoch_tag = tag; w.block_index = blk;
    w.lease_tag = lease; w.time_moves = moves;
    send_q.push_back(w);
  endtask

  // wait until every queued word has gone and every result has come back
  task automatic drain();
    while (send_q.size() > 0 || in_ch.valid || expect_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_EPOCH:  w_epoch = val;
      CFG_BLOCKS: w_blocks = val;
      default:    w_slots = val[5:0];
    endcase
  endtask

  // random lease: mostly small so completes can match, sometimes full width
  function automatic logic [63:0] rand_lease();
    if ($urandom_range(0, 9) == 0) return {$urandom(), $urandom()};
    return $urandom_range(1, 4);
  endfunction

  // a well-formed burst: admit a run of blocks near the frontier, complete
  // them out of order, tick them home; plus some noise
  task automatic queue_burst(int cnt, logic [31:0] base);
    logic [63:0] ls [8];
    int order [8];
    int j;
    int t;
    for (int i = 0; i < cnt; i++) begin
      ls[i] = rand_lease();
      order[i] = i;
      queue_word(OP_ADMIT, w_epoch, base + i, ls[i], $urandom_range(0, 1));
    end
    for (int i = cnt - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 11))
        0: queue_word(OP_COMPLETE, w_epoch, base + order[i], ls[order[i]] ^ 1, 0);
        1: queue_word(OP_QUERY, w_epoch ^ $urandom_range(0, 1), base + order[i], 0, 0);
        2: queue_word(OP_TICK, $urandom(), $urandom(), {$urandom(), $urandom()},
                      $urandom_range(0, 1));
        3: queue_word(OP_ADMIT, w_epoch, base + $urandom_range(0, 40), 0, 0);
        default: ;
      endcase
      queue_word(OP_COMPLETE, w_epoch, base + order[i], ls[order[i]], 0);
      if ($urandom_range(0, 3) == 0) queue_word(OP_TICK, 0, 0, 0, 1);
    end
    queue_word(OP_QUERY, w_epoch, base + $urandom_range(0, 7), 0, 0);
    queue_word(OP_TICK, $urandom(), base, 0, 1);
    queue_word(OP_TICK, 0, 0, 0, 0);
  endtask

  // run random traffic until about n words are queued
  task automatic random_phase(int n);
    int target;
    target = send_q.size() + n;
    while (send_q.size() < target) begin
      if ($urandom_range(0, 4) != 0)
        queue_burst($urandom_range(1, 8), frontier + send_q.size() % 3);
      else
        queue_word($urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? $urandom() : w_epoch,
                   $urandom_range(0, 70), rand_lease(), $urandom_range(0, 1));
    end
  endtask

  initial begin
    window_reset();
    rst_n = 0;
    cfg_we = 0; cfg_idx = CFG_EPOCH; cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed: before start, identity failures, field extremes
    queue_word(OP_COMPLETE, 1, 0, 5, 0);
    queue_word(OP_QUERY, 1, 0, 0, 0);
    queue_word(OP_ADMIT, 1, 0, 7, 0);
    queue_word(OP_ADMIT, 1, 0, 0, 0);
    queue_word(OP_ADMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    queue_word(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    queue_word(OP_ADMIT, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    queue_word(OP_ADMIT, 1, 0, 3, 0);
    queue_word(OP_COMPLETE, 1, 0, 3, 0);
    queue_word(OP_COMPLETE, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    queue_word(OP_QUERY, 1, 0, 0, 0);
    queue_word(OP_TICK, 0, 0, 0, 0);
    queue_word(OP_TICK, 0, 0, 0, 1);
    queue_word(OP_QUERY, 1, 0, 0, 0);
    queue_word(OP_QUERY, 1, 1, 0, 0);
    drain();

    // wide window, frontier far from the end
    write_reg(CFG_BLOCKS, 32'hFFFF_FFFF);
    write_reg(CFG_EPOCH, 32'hFFFF_FFFF);
    queue_word(OP_ADMIT, 32'hFFFF_FFFF, 32, 9, 0);
    queue_word(OP_ADMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 9, 0);
    queue_word(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 0);
    random_phase(200);

    // receiver holds off while the sender keeps offering words
    repeat (200) @(posedge clk);
    hold_off = 1;
    repeat (3000) @(posedge clk);
    hold_off = 0;
    drain();

    // smallest window, then out-of-range slot counts, then seven slots
    write_reg(CFG_SLOTS, 1);
    write_reg(CFG_EPOCH, 32'h1234_5678);
    random_phase(120);
    drain();
    write_reg(CFG_SLOTS, 0);
    random_phase(60);
    drain();
    write_reg(CFG_SLOTS, 6'h3F);
    write_reg(CFG_BLOCKS, frontier + 40);
    random_phase(150);
    drain();
    write_reg(CFG_SLOTS, 7);
    random_phase(80);
    drain();

    // zero blocks: every identity check fails
    write_reg(CFG_BLOCKS, 0);
    random_phase(25);
    drain();

    $display("Covered %0d result words, %0d retirements, final frontier %0d",
             n_words, n_ticks_retired, frontier);
    $display("Settings visited: slot counts 32, 1, 0, 63, 7; block counts 1 to max and 0");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
